/* design/sine_oscillator_fm_muladd_defines.svh */
// Assertion macros shared by the oscillator RTL.
`ifndef SINE_OSCILLATOR_FM_MULADD_DEFINES_SVH
`define SINE_OSCILLATOR_FM_MULADD_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SOFM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SOFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sofm_pkg.sv */
// Types and constants of the table-lookup sine oscillator.
package sofm_pkg;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Quarter-wave table word: unsigned Q1.30 in [0, 1.0].
    localparam int ROM_W = 31;

    localparam logic [30:0] HALF_PI_Q30   = 31'd1686629713;
    localparam logic [30:0] ONE_Q30       = 31'd1073741824;
    localparam logic [29:0] ROUND_Q30     = 30'h2000_0000;
    localparam logic [31:0] QUARTER_CYCLE = 32'h4000_0000;

    localparam logic [23:0] OUT_MAX = 24'h7F_FFFF;
    localparam logic [23:0] OUT_MIN = 24'h80_0000;

    // Taylor series: term n is divided by (2n)(2n+1), using a reciprocal
    // scaled by 2^33 and a single correction step.
    localparam int TAYLOR_TERMS = 10;
    localparam logic [3:0] TAYLOR_LAST = 4'd9;
    localparam int RECIP_SHIFT = 33;

    localparam logic [8:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
        9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd342, 9'd420
    };

    localparam logic [30:0] TAYLOR_RECIP [TAYLOR_TERMS] = '{
        31'((64'd1 << 33) / 64'd6),   31'((64'd1 << 33) / 64'd20),
        31'((64'd1 << 33) / 64'd42),  31'((64'd1 << 33) / 64'd72),
        31'((64'd1 << 33) / 64'd110), 31'((64'd1 << 33) / 64'd156),
        31'((64'd1 << 33) / 64'd210), 31'((64'd1 << 33) / 64'd272),
        31'((64'd1 << 33) / 64'd342), 31'((64'd1 << 33) / 64'd420)
    };

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE      = 2'd0;
    localparam logic [1:0] CFG_MUL_VALUE = 2'd1;
    localparam logic [1:0] CFG_ADD_VALUE = 2'd2;
    localparam logic [1:0] CFG_CONV_GAIN = 2'd3;

    localparam logic [1:0]  MODE_PER_SAMPLE = 2'd0;
    localparam logic [23:0] MUL_VALUE_RST   = 24'd65536;
    localparam logic [23:0] ADD_VALUE_RST   = 24'd0;
    localparam logic [31:0] CONV_GAIN_RST   = 32'd11453246;

    typedef enum logic [3:0] {
        ST_F_ANGLE,
        ST_F_SQUARE,
        ST_F_SERIES,
        ST_F_RECIP,
        ST_F_CHECK,
        ST_F_FIX,
        ST_F_ACCUM,
        ST_F_STORE,
        ST_IDLE,
        ST_S_T0,
        ST_S_T1,
        ST_S_STEP,
        ST_S_LERP,
        ST_S_GAIN,
        ST_S_OUT
    } state_t;

endpackage

/* design/sofm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sofm_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 513
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/sofm_mul.sv */
// Shared signed multiplier with a registered product.
module sofm_mul #(
    parameter int A_W = 34,
    parameter int B_W = 33
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [A_W-1:0]   a,
    input  logic signed [B_W-1:0]   b,
    output logic signed [A_W+B_W-1:0] p
);

    logic signed [A_W+B_W-1:0] prod_reg;

    // The product holds while en is low, so a consumer may wait on it.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign p = prod_reg;

endmodule

/* design/sine_oscillator_fm_muladd.sv */
// Top level of the table-lookup sine oscillator with interpolation, gain and offset.
//
// Numerically controlled sine oscillator. A 32-bit wrapping phase selects a sine
// table entry with its top TABLE_BITS bits and interpolates linearly between that
// entry and the next one with the remaining bits. The interpolated value is
// multiplied by a gain, an offset is added, the result is rounded half up to Q8.16
// and saturated, and then the phase advances by freq times conv_gain shifted right
// by 12 + TABLE_BITS bits. The gain comes from mul_value when bit 1 of the mode
// register is set, the offset from add_value when mode is nonzero, and each from the
// input transaction otherwise. A set-phase transaction (tuser high) loads the phase
// with phase_value plus a quarter cycle and produces no output. Only a quarter wave
// is stored, in a RAM of 2^(TABLE_BITS-2)+1 words; after reset the block computes it
// with a Taylor series on its one multiplier and holds s_tready low until the table
// is complete. Configuration writes are taken during that time as usual. Afterwards
// a sample transaction occupies the block from ST_S_T0 through ST_S_OUT, as its three
// multiplier passes and two RAM reads all go through the single shared multiplier and
// read port and ST_S_OUT waits for a free output register; a set-phase transaction
// leaves the block ready. A finished sample waits in an output register, so the next
// input transaction is taken while the previous result is still pending downstream.
module sine_oscillator_fm_muladd #(
    parameter int TABLE_BITS = 11
) (
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // freq [31:0], mul_in [55:32], add_in [79:56],
                                    // phase_value [111:80]
    input  logic [0:0]   s_tuser,   // command [0]: 0 sample, 1 set phase

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,   // sample_out [23:0]

    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    `include "sine_oscillator_fm_muladd_defines.svh"

    localparam int QUARTER     = 1 << (TABLE_BITS - 2);
    localparam int ROM_DEPTH   = QUARTER + 1;
    localparam int ADDR_W      = TABLE_BITS - 1;
    localparam int FRAC_BITS   = 32 - TABLE_BITS;
    localparam int STEP_SHIFT  = 12 + TABLE_BITS;
    localparam int ANGLE_SHIFT = TABLE_BITS - 2;
    localparam int A_W         = sofm_pkg::MUL_A_W;
    localparam int B_W         = sofm_pkg::MUL_B_W;
    localparam int P_W         = sofm_pkg::MUL_P_W;

    // Input transaction fields.
    logic [31:0] in_freq;
    logic [23:0] in_mul;
    logic [23:0] in_add;
    logic [31:0] in_phase;
    logic        in_set_phase;
    logic        in_accept;

    assign in_freq      = s_tdata[31:0];
    assign in_mul       = s_tdata[55:32];
    assign in_add       = s_tdata[79:56];
    assign in_phase     = s_tdata[111:80];
    assign in_set_phase = s_tuser[0];
    assign in_accept    = s_tvalid && s_tready;

    sofm_pkg::state_t state_reg, state_next;

    // Configuration registers and oscillator state.
    logic [1:0]  mode_reg;
    logic [23:0] mul_value_reg;
    logic [23:0] add_value_reg;
    logic [31:0] conv_gain_reg;
    logic [31:0] phase_reg;

    // Table fill sequencer.
    logic [ADDR_W-1:0] k_reg;
    logic [3:0]        n_reg;
    logic [30:0]       term_reg;
    logic [31:0]       x2_reg;
    logic [32:0]       q_reg;
    logic [30:0]       qe_reg;
    logic signed [33:0] sum_reg;

    // Sample datapath.
    logic signed [31:0] t0_reg;
    logic signed [32:0] diff_reg;
    logic signed [31:0] v_reg;
    logic [31:0]        step_reg;
    logic [31:0]        freq_reg;
    logic [23:0]        gain_reg;
    logic [23:0]        offset_reg;

    logic        out_valid_reg;
    logic [23:0] out_data_reg;
    logic        out_free;

    // Multiplier.
    logic                  mul_en;
    logic signed [A_W-1:0] mul_a;
    logic signed [B_W-1:0] mul_b;
    logic signed [P_W-1:0] prod;

    // Quarter-wave RAM.
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_rd_addr;
    logic [sofm_pkg::ROM_W-1:0] ram_rd_data;
    logic [sofm_pkg::ROM_W-1:0] ram_wr_data;

    logic fill_active;

    sofm_mul #(
        .A_W (A_W),
        .B_W (B_W)
    ) u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    sofm_ram #(
        .WIDTH (sofm_pkg::ROM_W),
        .DEPTH (ROM_DEPTH)
    ) u_rom (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (k_reg),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Views of the registered product used by the different steps.
    logic [30:0]        x_now;
    logic [31:0]        x2_now;
    logic [32:0]        q_now;
    logic [30:0]        qe_now;
    logic [31:0]        step_now;
    logic signed [31:0] lerp_now;

    assign x_now    = prod[ANGLE_SHIFT +: 31];
    assign x2_now   = prod[30 +: 32];
    assign q_now    = prod[30 +: 33];
    assign qe_now   = prod[sofm_pkg::RECIP_SHIFT +: 31];
    assign step_now = prod[STEP_SHIFT +: 32];
    assign lerp_now = prod[FRAC_BITS +: 32];

    // The reciprocal estimate is at most one below the true quotient, so one
    // compare against the divisor finishes the division.
    logic [33:0] rem;
    logic [30:0] term_fixed;

    assign rem        = {1'b0, q_reg} - prod[33:0];
    assign term_fixed = qe_reg + 31'(rem >= {25'd0, sofm_pkg::TAYLOR_DIV[n_reg]});

    // The series never leaves [0, 1.0] in practice, but the table word is
    // clamped there regardless.
    always_comb
    begin
        if (sum_reg[33])
        begin
            ram_wr_data = '0;
        end
        else if (sum_reg[32:0] > {2'b00, sofm_pkg::ONE_Q30})
        begin
            ram_wr_data = sofm_pkg::ONE_Q30;
        end
        else
        begin
            ram_wr_data = sum_reg[30:0];
        end
    end

    // Map a full-wave index onto the quarter-wave table: the second and fourth
    // quadrants run backwards, the second half of the wave is negated.
    logic [TABLE_BITS-1:0] idx0, idx1, idx_rd;
    logic [TABLE_BITS-3:0] idx_low;
    logic                  neg_now;
    logic signed [31:0]    table_val;

    assign idx0    = phase_reg[31 -: TABLE_BITS];
    assign idx1    = idx0 + TABLE_BITS'(1);
    assign idx_rd  = (state_reg == sofm_pkg::ST_S_T0) ? idx1 : idx0;
    assign idx_low = idx_rd[TABLE_BITS-3:0];

    assign ram_rd_addr = idx_rd[TABLE_BITS-2] ? (ADDR_W'(QUARTER) - {1'b0, idx_low})
                                              : {1'b0, idx_low};

    assign neg_now   = (state_reg == sofm_pkg::ST_S_T1) ? idx1[TABLE_BITS-1]
                                                        : idx0[TABLE_BITS-1];
    assign table_val = neg_now ? -$signed({1'b0, ram_rd_data}) : $signed({1'b0, ram_rd_data});

    // Output arithmetic: v * gain + offset * 2^30 + 2^29, keep bits 53:30 and saturate.
    logic [55:0] acc;
    logic [23:0] sample_next;

    assign acc = prod[55:0] + {{2{offset_reg[23]}}, offset_reg, 30'd0}
               + {26'd0, sofm_pkg::ROUND_Q30};

    always_comb
    begin
        if ((acc[55:53] == 3'b000) || (acc[55:53] == 3'b111))
        begin
            sample_next = acc[53:30];
        end
        else if (acc[55])
        begin
            sample_next = sofm_pkg::OUT_MIN;
        end
        else
        begin
            sample_next = sofm_pkg::OUT_MAX;
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sofm_pkg::ST_F_ANGLE:  state_next = sofm_pkg::ST_F_SQUARE;
            sofm_pkg::ST_F_SQUARE: state_next = sofm_pkg::ST_F_SERIES;
            sofm_pkg::ST_F_SERIES: state_next = sofm_pkg::ST_F_RECIP;
            sofm_pkg::ST_F_RECIP:  state_next = sofm_pkg::ST_F_CHECK;
            sofm_pkg::ST_F_CHECK:  state_next = sofm_pkg::ST_F_FIX;
            sofm_pkg::ST_F_FIX:    state_next = sofm_pkg::ST_F_ACCUM;
            sofm_pkg::ST_F_ACCUM:
            begin
                if (n_reg == sofm_pkg::TAYLOR_LAST)
                begin
                    state_next = sofm_pkg::ST_F_STORE;
                end
                else
                begin
                    state_next = sofm_pkg::ST_F_RECIP;
                end
            end
            sofm_pkg::ST_F_STORE:
            begin
                if (k_reg == ADDR_W'(QUARTER))
                begin
                    state_next = sofm_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = sofm_pkg::ST_F_ANGLE;
                end
            end
            sofm_pkg::ST_IDLE:
            begin
                if (in_accept && !in_set_phase)
                begin
                    state_next = sofm_pkg::ST_S_T0;
                end
            end
            sofm_pkg::ST_S_T0:   state_next = sofm_pkg::ST_S_T1;
            sofm_pkg::ST_S_T1:   state_next = sofm_pkg::ST_S_STEP;
            sofm_pkg::ST_S_STEP: state_next = sofm_pkg::ST_S_LERP;
            sofm_pkg::ST_S_LERP: state_next = sofm_pkg::ST_S_GAIN;
            sofm_pkg::ST_S_GAIN: state_next = sofm_pkg::ST_S_OUT;
            sofm_pkg::ST_S_OUT:
            begin
                if (out_free)
                begin
                    state_next = sofm_pkg::ST_IDLE;
                end
            end
            default: state_next = sofm_pkg::ST_F_ANGLE;
        endcase
    end

    // Multiplier operands and RAM write per state.
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        ram_we = 1'b0;
        case (state_reg)
            sofm_pkg::ST_F_ANGLE:
            begin
                mul_en = 1'b1;
                mul_a  = {{(A_W-31){1'b0}}, sofm_pkg::HALF_PI_Q30};
                mul_b  = {{(B_W-ADDR_W){1'b0}}, k_reg};
            end
            sofm_pkg::ST_F_SQUARE:
            begin
                mul_en = 1'b1;
                mul_a  = {{(A_W-31){1'b0}}, x_now};
                mul_b  = {{(B_W-31){1'b0}}, x_now};
            end
            sofm_pkg::ST_F_SERIES:
            begin
                mul_en = 1'b1;
                mul_a  = {{(A_W-31){1'b0}}, term_reg};
                mul_b  = {{(B_W-32){1'b0}}, x2_now};
            end
            sofm_pkg::ST_F_RECIP:
            begin
                mul_en = 1'b1;
                mul_a  = {{(A_W-33){1'b0}}, q_now};
                mul_b  = {{(B_W-31){1'b0}}, sofm_pkg::TAYLOR_RECIP[n_reg]};
            end
            sofm_pkg::ST_F_CHECK:
            begin
                mul_en = 1'b1;
                mul_a  = {{(A_W-31){1'b0}}, qe_now};
                mul_b  = {{(B_W-9){1'b0}}, sofm_pkg::TAYLOR_DIV[n_reg]};
            end
            sofm_pkg::ST_F_ACCUM:
            begin
                mul_en = (n_reg != sofm_pkg::TAYLOR_LAST);
                mul_a  = {{(A_W-31){1'b0}}, term_reg};
                mul_b  = {{(B_W-32){1'b0}}, x2_reg};
            end
            sofm_pkg::ST_F_STORE:
            begin
                ram_we = 1'b1;
            end
            sofm_pkg::ST_S_T1:
            begin
                mul_en = 1'b1;
                mul_a  = {{(A_W-32){freq_reg[31]}}, freq_reg};
                mul_b  = {{(B_W-32){1'b0}}, conv_gain_reg};
            end
            sofm_pkg::ST_S_STEP:
            begin
                mul_en = 1'b1;
                mul_a  = {{(A_W-33){diff_reg[32]}}, diff_reg};
                mul_b  = {{(B_W-FRAC_BITS){1'b0}}, phase_reg[FRAC_BITS-1:0]};
            end
            sofm_pkg::ST_S_GAIN:
            begin
                mul_en = 1'b1;
                mul_a  = {{(A_W-32){v_reg[31]}}, v_reg};
                mul_b  = {{(B_W-24){gain_reg[23]}}, gain_reg};
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sofm_pkg::ST_F_ANGLE;
            k_reg         <= '0;
            n_reg         <= '0;
            phase_reg     <= sofm_pkg::QUARTER_CYCLE;
            mode_reg      <= sofm_pkg::MODE_PER_SAMPLE;
            mul_value_reg <= sofm_pkg::MUL_VALUE_RST;
            add_value_reg <= sofm_pkg::ADD_VALUE_RST;
            conv_gain_reg <= sofm_pkg::CONV_GAIN_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if ((state_reg == sofm_pkg::ST_F_STORE) && (k_reg != ADDR_W'(QUARTER)))
            begin
                k_reg <= k_reg + ADDR_W'(1);
            end

            if (state_reg == sofm_pkg::ST_F_SQUARE)
            begin
                n_reg <= '0;
            end
            else if ((state_reg == sofm_pkg::ST_F_ACCUM) && (n_reg != sofm_pkg::TAYLOR_LAST))
            begin
                n_reg <= n_reg + 4'd1;
            end

            if (in_accept && in_set_phase)
            begin
                phase_reg <= in_phase + sofm_pkg::QUARTER_CYCLE;
            end
            else if ((state_reg == sofm_pkg::ST_S_OUT) && out_free)
            begin
                phase_reg <= phase_reg + step_reg;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    sofm_pkg::CFG_MODE:      mode_reg      <= cfg_data[1:0];
                    sofm_pkg::CFG_MUL_VALUE: mul_value_reg <= cfg_data[23:0];
                    sofm_pkg::CFG_ADD_VALUE: add_value_reg <= cfg_data[23:0];
                    sofm_pkg::CFG_CONV_GAIN: conv_gain_reg <= cfg_data;
                    default:                 mode_reg      <= mode_reg;
                endcase
            end

            if ((state_reg == sofm_pkg::ST_S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            sofm_pkg::ST_F_SQUARE:
            begin
                term_reg <= x_now;
                sum_reg  <= {3'b000, x_now};
            end
            sofm_pkg::ST_F_SERIES:
            begin
                x2_reg <= x2_now;
            end
            sofm_pkg::ST_F_RECIP:
            begin
                q_reg <= q_now;
            end
            sofm_pkg::ST_F_CHECK:
            begin
                qe_reg <= qe_now;
            end
            sofm_pkg::ST_F_FIX:
            begin
                term_reg <= term_fixed;
            end
            sofm_pkg::ST_F_ACCUM:
            begin
                // Odd terms (first, third, ...) are subtracted.
                if (!n_reg[0])
                begin
                    sum_reg <= sum_reg - $signed({3'b000, term_reg});
                end
                else
                begin
                    sum_reg <= sum_reg + $signed({3'b000, term_reg});
                end
            end
            sofm_pkg::ST_IDLE:
            begin
                freq_reg   <= in_freq;
                gain_reg   <= mode_reg[1] ? mul_value_reg : in_mul;
                offset_reg <= (mode_reg != sofm_pkg::MODE_PER_SAMPLE) ? add_value_reg : in_add;
            end
            sofm_pkg::ST_S_T0:
            begin
                t0_reg <= table_val;
            end
            sofm_pkg::ST_S_T1:
            begin
                diff_reg <= {table_val[31], table_val} - {t0_reg[31], t0_reg};
            end
            sofm_pkg::ST_S_STEP:
            begin
                step_reg <= step_now;
            end
            sofm_pkg::ST_S_LERP:
            begin
                v_reg <= t0_reg + lerp_now;
            end
            sofm_pkg::ST_S_OUT:
            begin
                if (out_free)
                begin
                    out_data_reg <= sample_next;
                end
            end
            default:
            begin
                t0_reg <= t0_reg;
            end
        endcase
    end

    assign s_tready = (state_reg == sofm_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign fill_active = (state_reg == sofm_pkg::ST_F_ANGLE)
                      || (state_reg == sofm_pkg::ST_F_SQUARE)
                      || (state_reg == sofm_pkg::ST_F_SERIES)
                      || (state_reg == sofm_pkg::ST_F_RECIP)
                      || (state_reg == sofm_pkg::ST_F_CHECK)
                      || (state_reg == sofm_pkg::ST_F_FIX)
                      || (state_reg == sofm_pkg::ST_F_ACCUM)
                      || (state_reg == sofm_pkg::ST_F_STORE);

    `SOFM_ASSERT_IMPLIES(a_fill_blocks_input, clk, rst_n, fill_active, !s_tready,
        "input accepted while the sine table is still being built")
    `SOFM_ASSERT_IMPLIES(a_rom_word_bounded, clk, rst_n, ram_we,
        ram_wr_data <= sofm_pkg::ONE_Q30, "table word above 1.0")
    `SOFM_ASSERT_NEXT(a_result_loaded, clk, rst_n,
        (state_reg == sofm_pkg::ST_S_OUT) && out_free, m_tvalid,
        "finished sample not presented on the output")
    `SOFM_ASSERT_NEXT(a_set_phase_no_busy, clk, rst_n,
        s_tvalid && s_tready && s_tuser[0], s_tready,
        "set-phase transaction left the block busy")

endmodule
